// File: hw/rtl/property_sync_status_table_defines.svh
// Assertion macros for the property sync status table.
// Sampled on the block clock, disabled while the synchronous reset is high.
`ifndef PROPERTY_SYNC_STATUS_TABLE_DEFINES_SVH
`define PROPERTY_SYNC_STATUS_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PST_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define PST_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PST_ASSERT_IMPL(lbl, ante, cons, msg)
`define PST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hw/rtl/pst_pkg.sv
// Shared types and constants of the property sync status table.
// No dependencies; used by pst_update and property_sync_status_table.
`default_nettype none

package pst_pkg;

   localparam int IDX_W   = 4;
   localparam int VALUE_W = 16;
   localparam int TIME_W  = 32;

   // Status byte flags
   localparam logic [7:0] ST_PUSH      = 8'h10;
   localparam logic [7:0] ST_PULL      = 8'h20;
   localparam logic [7:0] ST_WAIT      = 8'h40;
   localparam logic [7:0] ST_FORCE     = 8'h80;
   localparam logic [7:0] ST_FLAG_MASK = 8'hF0;
   localparam logic [2:0] FAIL_MAX     = 3'd7;

   typedef logic [4:0] pcount_type;

   typedef enum logic [2:0] {
      CMD_WRITE      = 3'd0,
      CMD_READ       = 3'd1,
      CMD_INIT_PUSH  = 3'd2,
      CMD_CHECK      = 3'd3,
      CMD_SEND_FAIL  = 3'd4,
      CMD_SEND_OK    = 3'd5,
      CMD_NEEDS_PULL = 3'd6
   } cmd_type;

   typedef struct packed {
      logic [2:0]         command;
      logic [IDX_W-1:0]   index;
      logic [VALUE_W-1:0] write_value;
      logic               external;
      logic               is_rate;
      logic [TIME_W-1:0]  time_ms;
   } req_type;

   typedef struct packed {
      logic               value_we;
      logic [VALUE_W-1:0] value;
      logic [7:0]         status;
      logic               dirty;
      logic               request_update;
      logic               request_reschedule;
   } upd_type;

endpackage

`default_nettype wire

// File: hw/rtl/pst_update.sv
// Per-command update of one table entry: new status, new value, result flags.
// Depends on pst_pkg.
`default_nettype none

module pst_update (
   input  pst_pkg::req_type req,
   input  logic [7:0]       cur_status,
   input  logic [15:0]      cur_value,
   output pst_pkg::upd_type upd
);
   import pst_pkg::*;

   logic [2:0] fail_cnt;
   logic [2:0] fail_next;
   logic       phase;
   logic       due;

   always_comb begin
      fail_cnt  = cur_status[3:1];
      fail_next = (fail_cnt == FAIL_MAX) ? FAIL_MAX : fail_cnt + 3'd1;
      phase     = ~req.time_ms[{fail_next, 1'b0}];

      // Due when push or pull pending and, after two or more failures, the
      // time bit picked by the failure count matches the stored phase.
      if ((cur_status & (ST_PUSH | ST_PULL)) == 8'h00) begin
         due = 1'b0;
      end else if (cur_status[3:2] == 2'b00) begin
         due = 1'b1;
      end else begin
         due = (cur_status[0] == req.time_ms[{cur_status[3:1], 1'b0}]);
      end

      upd.value_we           = 1'b0;
      upd.value              = cur_value;
      upd.status             = cur_status;
      upd.dirty              = 1'b0;
      upd.request_update     = 1'b0;
      upd.request_reschedule = 1'b0;

      case (cmd_type'(req.command))
         CMD_WRITE: begin
            if (req.external || (cur_value != req.write_value)) begin
               upd.value_we           = 1'b1;
               upd.value              = req.write_value;
               upd.status             = (cur_status | ST_PUSH) & ~(ST_PULL | ST_WAIT);
               upd.request_update     = req.external;
               upd.request_reschedule = req.is_rate;
            end
         end
         CMD_INIT_PUSH: begin
            if ((cur_status & (ST_PULL | ST_WAIT)) != 8'h00) begin
               upd.status = cur_status | ST_FORCE;
            end else begin
               upd.status = ST_PUSH | ST_FORCE;
            end
         end
         CMD_CHECK: begin
            upd.dirty = due;
         end
         CMD_SEND_FAIL: begin
            upd.status = (cur_status & ST_FLAG_MASK) | {4'h0, fail_next, phase};
         end
         CMD_SEND_OK: begin
            if ((cur_status & ST_PUSH) != 8'h00) begin
               upd.status = cur_status & ST_FLAG_MASK & ~(ST_PUSH | ST_FORCE);
            end else begin
               upd.status = (cur_status & ST_FLAG_MASK & ~ST_PULL) | ST_WAIT;
            end
         end
         CMD_NEEDS_PULL: begin
            upd.status = cur_status | ST_PULL;
         end
         default: begin
            // read and the unused code leave the entry as it is
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/property_sync_status_table.sv
// Property sync status table: top level with input and result registers.
// Depends on pst_pkg, pst_update and property_sync_status_table_defines.svh.
// Usage:
//   Request words (req_*) carry one command on one property: write, read,
//   init push, check due, send failed, send succeeded, needs pull. A word is
//   taken at a clock edge with req_valid high and req_stall low.
//   Result words (rsp_*) carry the error flag, the value and status byte of
//   the property after the command, and the dirty / update / reschedule
//   flags; a word leaves at an edge with rsp_valid high and rsp_stall low.
//   csr_wr_en / csr_wr_data write the property count (5 bits, reset 16);
//   indices at or above it, or at or above MAX_PROPERTIES, report not found
//   with all other result fields zero. Write it only while the block is idle.
// Timing:
//   A word passes the request register, then the result register. One word
//   per cycle unless rsp_stall holds a result; each word's read-modify-write
//   lands before the next word reads the entry.
// Reset: synchronous, active high. Clears the valid bits of both registers, every value and
//   status entry, and sets the property count to 16. No clearing pass.
// Backpressure: while rsp_stall holds a result, the request register holds
//   too; req_stall rises only once that register is full behind it.
`default_nettype none

`include "property_sync_status_table_defines.svh"

module property_sync_status_table #(
   parameter int MAX_PROPERTIES = 16
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_command,
   input  logic [3:0]          req_property_index,
   input  logic signed [15:0]  req_write_value,
   input  logic                req_external,
   input  logic                req_is_rate_property,
   input  logic [31:0]         req_time_ms,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_error,
   output logic signed [15:0]  rsp_read_value,
   output logic [7:0]          rsp_status_out,
   output logic                rsp_dirty,
   output logic                rsp_request_update,
   output logic                rsp_request_reschedule,

   input  logic                csr_wr_en,
   input  pst_pkg::pcount_type csr_wr_data
);
   import pst_pkg::*;

   // Only indices the 4-bit field can reach need storage.
   localparam int NumIdx = 1 << IDX_W;
   localparam int Depth  = (MAX_PROPERTIES < NumIdx) ? MAX_PROPERTIES : NumIdx;
   localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;

   // Property count register
   pcount_type pcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff <= pcount_type'(NumIdx);
      end else if (csr_wr_en) begin
         pcount_ff <= csr_wr_data;
      end
   end

   // Request register
   logic    s1_valid_ff;
   req_type s1_req_ff;
   logic    advance;

   // Result register drains or is empty: the request word moves on.
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_req_ff.command     <= req_command;
         s1_req_ff.index       <= req_property_index;
         s1_req_ff.write_value <= req_write_value;
         s1_req_ff.external    <= req_external;
         s1_req_ff.is_rate     <= req_is_rate_property;
         s1_req_ff.time_ms     <= req_time_ms;
      end
   end

   // Entry lookup and bounds check
   logic [7:0]       status_ff [Depth];
   logic [15:0]      value_ff  [Depth];
   logic [AddrW-1:0] addr;
   logic             found;
   logic             fire;
   upd_type          upd;

   assign addr  = AddrW'(s1_req_ff.index);
   assign found = ({1'b0, s1_req_ff.index} < pcount_ff)
                  && (32'(s1_req_ff.index) < 32'(MAX_PROPERTIES));
   assign fire  = s1_valid_ff && advance;

   pst_update u_update (
      .req        (s1_req_ff),
      .cur_status (status_ff[addr]),
      .cur_value  (value_ff[addr]),
      .upd        (upd)
   );

   // Write back the entry as the word moves on; not-found words change nothing.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Depth; i++) begin
            status_ff[i] <= 8'h00;
            value_ff[i]  <= 16'h0000;
         end
      end else if (fire && found) begin
         status_ff[addr] <= upd.status;
         if (upd.value_we) begin
            value_ff[addr] <= upd.value;
         end
      end
   end

   // Result register
   logic    rsp_valid_ff;
   logic    rsp_error_ff;
   upd_type rsp_ff;
   upd_type rsp_in;

   always_comb begin
      rsp_in = upd;
      if (!found) begin
         rsp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_error_ff <= !found;
         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_error              = rsp_error_ff;
   assign rsp_read_value         = $signed(rsp_ff.value);
   assign rsp_status_out         = rsp_ff.status;
   assign rsp_dirty              = rsp_ff.dirty;
   assign rsp_request_update     = rsp_ff.request_update;
   assign rsp_request_reschedule = rsp_ff.request_reschedule;

   // Checks
   `PST_ASSERT_IMPL(a_notfound_zero, rsp_valid && rsp_error,
      (rsp_read_value == 16'sd0) && (rsp_status_out == 8'h00) && !rsp_dirty
      && !rsp_request_update && !rsp_request_reschedule,
      "not-found result carries nonzero fields")
   `PST_ASSERT_IMPL(a_dirty_pending, rsp_valid && rsp_dirty,
      (rsp_status_out & (ST_PUSH | ST_PULL)) != 8'h00,
      "dirty reported without push or pull pending")
   `PST_ASSERT_IMPL(a_resched_push, rsp_valid && rsp_request_reschedule,
      rsp_status_out[4] && !rsp_status_out[5] && !rsp_status_out[6],
      "reschedule without a write taking effect")
   `PST_ASSERT_NEXT(a_stall_holds, req_stall,
      s1_valid_ff && rsp_valid,
      "request stalled without a held word ahead")

endmodule

`default_nettype wire

// File: tb/sv/property_sync_status_table_tb.sv
// Self-checking testbench for property_sync_status_table: a queued request driver and a
// result monitor around an in-order predictor of the value and status tables.
// Depends on pst_pkg and the property_sync_status_table RTL; reads no files.
`timescale 1ns / 1ps

module property_sync_status_table_tb;
   import pst_pkg::*;

   localparam int PROP_SLOTS = 16;        // table depth the block is built with
   localparam int CYCLE_LIMIT = 200000;   // watchdog bound on the whole run
   localparam int HOLD_CYCLES = 90;       // long receiver hold-off in the pressure phase
   localparam logic [2:0] CMD_UNUSED = 3'd7;
   localparam logic [7:0] ST_FAIL_MASK = 8'h0E;
   localparam logic [7:0] ST_BACKOFF = 8'h0C;

   typedef struct packed {
      logic [2:0]  command;
      logic [3:0]  index;
      logic [15:0] write_value;
      logic        external;
      logic        is_rate;
      logic [31:0] time_ms;
   } command_word_type;

   typedef struct packed {
      logic        error;
      logic [15:0] value;
      logic [7:0]  status;
      logic        dirty;
      logic        request_update;
      logic        request_reschedule;
   } table_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_command = CMD_READ;
   logic [3:0]  req_property_index = '0;
   logic [15:0] req_write_value = '0;
   logic        req_external = 1'b0;
   logic        req_is_rate_property = 1'b0;
   logic [31:0] req_time_ms = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_error;
   logic [15:0] rsp_read_value;
   logic [7:0]  rsp_status_out;
   logic        rsp_dirty;
   logic        rsp_request_update;
   logic        rsp_request_reschedule;

   logic       csr_wr_en = 1'b0;
   pcount_type csr_wr_data = 5'd16;

   // Predictor state: shadow copies of both tables and the property count.
   logic [7:0]  shadow_status [PROP_SLOTS];
   logic [15:0] shadow_value [PROP_SLOTS];
   pcount_type  shadow_count = 5'd16;

   command_word_type pending_commands[$];
   table_result_type expected_results[$];

   // Idle shaping, set per phase by the stimulus block.
   int req_gap_pct = 0;
   int rsp_gap_pct = 0;
   int gap_left = 0;
   int stall_left = 0;
   int hold_left = 0;
   bit hold_request = 1'b0;
   bit hold_done = 1'b0;

   int error_count = 0;
   int word_count = 0;
   int not_found_count = 0;
   int due_count = 0;
   int update_count = 0;
   int setting_count = 0;
   int cycle_count = 0;

   property_sync_status_table #(
      .MAX_PROPERTIES(PROP_SLOTS)
   ) u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_command            (req_command),
      .req_property_index     (req_property_index),
      .req_write_value        (req_write_value),
      .req_external           (req_external),
      .req_is_rate_property   (req_is_rate_property),
      .req_time_ms            (req_time_ms),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_error              (rsp_error),
      .rsp_read_value         (rsp_read_value),
      .rsp_status_out         (rsp_status_out),
      .rsp_dirty              (rsp_dirty),
      .rsp_request_update     (rsp_request_update),
      .rsp_request_reschedule (rsp_request_reschedule),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data)
   );

   always #2 clock = ~clock;

   // Run one command against the shadow tables and return the result word it must produce.
   function automatic table_result_type apply_command(command_word_type w);
      table_result_type r;
      logic [7:0] s;
      logic [2:0] fails;
      logic [3:0] shift;
      int active;
      r = '0;
      active = (shadow_count < PROP_SLOTS) ? int'(shadow_count) : PROP_SLOTS;
      // Out-of-range index: everything but the error flag reads zero, tables untouched.
      if (int'(w.index) >= active) begin
         r.error = 1'b1;
         not_found_count++;
         return r;
      end
      s = shadow_status[w.index];
      case (w.command)
         CMD_WRITE: begin
            // Write only lands when it is external or actually changes the value.
            if (w.external || shadow_value[w.index] != w.write_value) begin
               shadow_value[w.index] = w.write_value;
               s = (s | ST_PUSH) & ~(ST_PULL | ST_WAIT);
               r.request_update = w.external;
               r.request_reschedule = w.is_rate;
            end
         end
         CMD_INIT_PUSH: begin
            if ((s & (ST_PULL | ST_WAIT)) != 8'h00)
               s = s | ST_FORCE;
            else
               s = ST_PUSH | ST_FORCE;
         end
         CMD_CHECK: begin
            // Due when push/pull is pending and either fewer than two failures are on
            // record or the chosen time bit matches the stored phase bit.
            shift = s[3:0] & ST_FAIL_MASK[3:0];
            if ((s & (ST_PUSH | ST_PULL)) == 8'h00)
               r.dirty = 1'b0;
            else if ((s & ST_BACKOFF) == 8'h00)
               r.dirty = 1'b1;
            else
               r.dirty = (s[0] == w.time_ms[shift]);
         end
         CMD_SEND_FAIL: begin
            fails = s[3:1];
            if (fails != FAIL_MAX)
               fails = fails + 3'd1;
            shift = {fails, 1'b0};
            s = (s & ST_FLAG_MASK) | {4'h0, fails, ~w.time_ms[shift]};
         end
         CMD_SEND_OK: begin
            if ((s & ST_PUSH) != 8'h00)
               s = s & ST_FLAG_MASK & ~(ST_PUSH | ST_FORCE);
            else
               s = (s & ST_FLAG_MASK & ~ST_PULL) | ST_WAIT;
         end
         CMD_NEEDS_PULL: s = s | ST_PULL;
         default: ;   // read and the unused code leave the entry alone
      endcase
      shadow_status[w.index] = s;
      r.value = shadow_value[w.index];
      r.status = s;
      if (r.dirty) due_count++;
      if (r.request_update) update_count++;
      return r;
   endfunction

   // Request driver: retire the accepted word into the predictor, then hold, idle
   // or present the next queued word. Valid only drops between words, never under stall.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(apply_command(pending_commands.pop_front()));
            word_count++;
         end
         if (req_valid && req_stall) begin
            // hold the stalled word as it is
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_commands.size() == 0) begin
            req_valid <= 1'b0;
         end else if (req_gap_pct != 0 && $urandom_range(1, 100) <= req_gap_pct) begin
            gap_left = $urandom_range(1, 14) - 1;
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_command <= pending_commands[0].command;
            req_property_index <= pending_commands[0].index;
            req_write_value <= pending_commands[0].write_value;
            req_external <= pending_commands[0].external;
            req_is_rate_property <= pending_commands[0].is_rate;
            req_time_ms <= pending_commands[0].time_ms;
         end
      end
   end

   // Compare one accepted result word against the oldest prediction.
   task automatic check_result();
      table_result_type want;
      if (expected_results.size() == 0) begin
         $error("result word arrived with no command outstanding");
         error_count++;
      end else begin
         want = expected_results.pop_front();
         if (rsp_error !== want.error) begin
            $error("error: expected %0d, actual %0d", want.error, rsp_error);
            error_count++;
         end
         if (rsp_read_value !== want.value) begin
            $error("read_value: expected %h, actual %h", want.value, rsp_read_value);
            error_count++;
         end
         if (rsp_status_out !== want.status) begin
            $error("status_out: expected %h, actual %h", want.status, rsp_status_out);
            error_count++;
         end
         if (rsp_dirty !== want.dirty) begin
            $error("dirty: expected %0d, actual %0d", want.dirty, rsp_dirty);
            error_count++;
         end
         if (rsp_request_update !== want.request_update) begin
            $error("request_update: expected %0d, actual %0d",
                   want.request_update, rsp_request_update);
            error_count++;
         end
         if (rsp_request_reschedule !== want.request_reschedule) begin
            $error("request_reschedule: expected %0d, actual %0d",
                   want.request_reschedule, rsp_request_reschedule);
            error_count++;
         end
      end
   endtask

   // Result monitor: check accepted words, then pick the next stall value. A requested
   // long hold-off is counted down here so the block fills and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_result();
         if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_gap_pct != 0 && $urandom_range(1, 100) <= rsp_gap_pct) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("Verification failed");
         $finish;
      end
   end

   task automatic queue_command(logic [2:0] cmd, logic [3:0] idx, logic [15:0] value,
                                logic ext, logic rate, logic [31:0] t);
      command_word_type w;
      w.command = cmd;
      w.index = idx;
      w.write_value = value;
      w.external = ext;
      w.is_rate = rate;
      w.time_ms = t;
      pending_commands.push_back(w);
   endtask

   // Random command with weights that favor writes, due checks and failure reports,
   // so backoff states with two or more failures are reached often.
   task automatic queue_random_command(int active);
      int pick;
      logic [2:0] cmd;
      logic [3:0] idx;
      logic [15:0] value;
      pick = $urandom_range(0, 99);
      if (pick < 25) cmd = CMD_WRITE;
      else if (pick < 33) cmd = CMD_READ;
      else if (pick < 41) cmd = CMD_INIT_PUSH;
      else if (pick < 63) cmd = CMD_CHECK;
      else if (pick < 80) cmd = CMD_SEND_FAIL;
      else if (pick < 90) cmd = CMD_SEND_OK;
      else if (pick < 98) cmd = CMD_NEEDS_PULL;
      else cmd = CMD_UNUSED;
      if (active > 0 && $urandom_range(0, 99) < 88)
         idx = 4'($urandom_range(0, active - 1));
      else
         idx = 4'($urandom_range(0, 15));
      // Small values make repeated non-external writes of the same value likely.
      if ($urandom_range(0, 99) < 30)
         value = 16'($urandom_range(0, 3));
      else
         value = 16'($urandom);
      queue_command(cmd, idx, value, 1'($urandom_range(0, 1)), $urandom_range(0, 9) < 3,
                    $urandom);
   endtask

   // Drain the pipeline, change the property count while idle, then load a phase.
   task automatic run_phase(pcount_type count, int n, int req_pct, int rsp_pct, bit hold);
      int active;
      while (pending_commands.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= count;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_count = count;
      setting_count++;
      req_gap_pct = req_pct;
      rsp_gap_pct = rsp_pct;
      active = (count < PROP_SLOTS) ? int'(count) : PROP_SLOTS;
      for (int i = 0; i < n; i++)
         queue_random_command(active);
      if (hold)
         hold_request = 1'b1;
   endtask

   initial begin
      for (int i = 0; i < PROP_SLOTS; i++) begin
         shadow_status[i] = '0;
         shadow_value[i] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed opening at the reset count of 16.
      req_gap_pct = 10;
      rsp_gap_pct = 10;
      queue_command(CMD_READ, 4'd0, 16'h0000, 1'b0, 1'b0, 32'h0);
      queue_command(CMD_CHECK, 4'd0, 16'h0000, 1'b0, 1'b0, 32'h0);
      queue_command(CMD_WRITE, 4'd0, 16'h7FFF, 1'b0, 1'b1, 32'h0);
      // same value, not external: no effect
      queue_command(CMD_WRITE, 4'd0, 16'h7FFF, 1'b0, 1'b1, 32'h0);
      // same value, external: forced through
      queue_command(CMD_WRITE, 4'd0, 16'h7FFF, 1'b1, 1'b0, 32'h0);
      queue_command(CMD_CHECK, 4'd0, 16'h0000, 1'b0, 1'b0, 32'h0);
      queue_command(CMD_SEND_FAIL, 4'd0, 16'h0000, 1'b0, 1'b0, 32'h0);
      queue_command(CMD_CHECK, 4'd0, 16'h0000, 1'b0, 1'b0, 32'hFFFF_FFFF);
      queue_command(CMD_SEND_FAIL, 4'd0, 16'h0000, 1'b0, 1'b0, 32'hFFFF_FFFF);
      // two failures: due only when the time bit matches the phase bit
      queue_command(CMD_CHECK, 4'd0, 16'h0000, 1'b0, 1'b0, 32'h0000_0000);
      queue_command(CMD_CHECK, 4'd0, 16'h0000, 1'b0, 1'b0, 32'h0000_0010);
      // drive the failure count into saturation
      for (int i = 0; i < 6; i++)
         queue_command(CMD_SEND_FAIL, 4'd0, 16'h0000, 1'b0, 1'b0,
                       i[0] ? 32'h5555_5555 : 32'hAAAA_AAAA);
      queue_command(CMD_CHECK, 4'd0, 16'h0000, 1'b0, 1'b0, 32'h0000_4000);
      queue_command(CMD_SEND_OK, 4'd0, 16'h0000, 1'b0, 1'b0, 32'h0);
      queue_command(CMD_SEND_OK, 4'd0, 16'h0000, 1'b0, 1'b0, 32'h0);
      queue_command(CMD_INIT_PUSH, 4'd0, 16'h0000, 1'b0, 1'b0, 32'h0);
      queue_command(CMD_NEEDS_PULL, 4'd15, 16'h0000, 1'b0, 1'b0, 32'h0);
      queue_command(CMD_INIT_PUSH, 4'd15, 16'h0000, 1'b0, 1'b0, 32'h0);
      queue_command(CMD_WRITE, 4'd15, 16'h8000, 1'b1, 1'b1, 32'h0);
      queue_command(CMD_SEND_OK, 4'd15, 16'h0000, 1'b0, 1'b0, 32'h0);
      queue_command(CMD_INIT_PUSH, 4'd3, 16'h0000, 1'b0, 1'b0, 32'h0);
      queue_command(CMD_UNUSED, 4'd15, 16'hFFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
      queue_command(CMD_WRITE, 4'd5, 16'hFFFF, 1'b0, 1'b0, 32'h0);

      // Random phases across property counts: a few active entries, none, one,
      // the largest register value, a long receiver hold-off, just above the table.
      run_phase(5'd4, 150, 10, 10, 1'b0);
      run_phase(5'd0, 20, 5, 5, 1'b0);
      run_phase(5'd1, 40, 0, 0, 1'b0);
      run_phase(5'd31, 80, 15, 15, 1'b0);
      run_phase(5'd16, 100, 8, 8, 1'b1);
      run_phase(5'd17, 40, 10, 20, 1'b0);
      // Final stretch at full rate on both sides.
      run_phase(5'd7, 100, 0, 0, 1'b0);

      while (pending_commands.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);

      $display("Checked %0d commands over %0d property-count settings.",
               word_count, setting_count);
      $display("Saw %0d not-found results, %0d due checks and %0d external updates.",
               not_found_count, due_count, update_count);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
